// ===== src/u8u16_pkg.sv =====
package u8u16_pkg;

   // Lead byte class boundaries and continuation payload mask.
   localparam logic [7:0]  ASCII_MAX      = 8'h7F;
   localparam logic [7:0]  CONT_MAX       = 8'hBF;
   localparam logic [7:0]  LEAD2_MAX      = 8'hDF;
   localparam logic [7:0]  LEAD3_MAX      = 8'hEF;
   localparam logic [7:0]  LEAD4_MAX      = 8'hF7;
   localparam logic [5:0]  CONT_MASK      = 6'h3F;

   // Code point limits.
   localparam logic [20:0] SURR_LOW       = 21'h00D800;
   localparam logic [20:0] SURR_HIGH      = 21'h00DFFF;
   localparam logic [20:0] CP_MAX         = 21'h10FFFF;
   localparam logic [20:0] BMP_MAX        = 21'h00FFFF;
   localparam logic [20:0] SUPP_BASE      = 21'h010000;
   localparam logic [5:0]  HIGH_SURR_TOP  = 6'b110110;
   localparam logic [5:0]  LOW_SURR_TOP   = 6'b110111;

   localparam int unsigned UNIT_WIDTH     = 16;
   localparam int unsigned ACCUM_WIDTH    = 21;

   // One decoded event handed from the front to the back.
   typedef struct packed {
      logic                  is_error;
      logic                  is_pair;
      logic [UNIT_WIDTH-1:0] unit_first;
      logic [UNIT_WIDTH-1:0] unit_second;
   } entry_type;

   // Queue status seen by the front and the back.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ===== src/u8u16_front.sv =====
module u8u16_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_byte_in,
   input  logic                req_end_of_string,
   input  u8u16_pkg::queue_status_type q_status,
   output logic                push,
   output u8u16_pkg::entry_type push_entry
);

   logic [1:0]                         pending_ff, pending_in;
   logic [u8u16_pkg::ACCUM_WIDTH-1:0]  accum_ff, accum_in;
   logic                               accept;
   logic                               emit_cp;
   logic                               fail;
   logic [u8u16_pkg::ACCUM_WIDTH-1:0]  cp;
   logic [u8u16_pkg::ACCUM_WIDTH-1:0]  supp;
   logic                               bad_cp;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !q_status.full;

   always_comb begin
      pending_in = pending_ff;
      accum_in   = accum_ff;
      emit_cp    = 1'b0;
      fail       = 1'b0;
      cp         = '0;
      if (pending_ff == 2'd0) begin
         case (req_byte_in) inside
            [8'h00:u8u16_pkg::ASCII_MAX]: begin
               accum_in = '0;
               emit_cp  = 1'b1;
               cp       = {13'd0, req_byte_in};
            end
            [8'h80:u8u16_pkg::CONT_MAX]: begin
               fail = 1'b1;
            end
            [8'hC0:u8u16_pkg::LEAD2_MAX]: begin
               accum_in   = {16'd0, req_byte_in[4:0]};
               pending_in = 2'd1;
               fail       = req_end_of_string;
            end
            [8'hE0:u8u16_pkg::LEAD3_MAX]: begin
               accum_in   = {17'd0, req_byte_in[3:0]};
               pending_in = 2'd2;
               fail       = req_end_of_string;
            end
            [8'hF0:u8u16_pkg::LEAD4_MAX]: begin
               accum_in   = {18'd0, req_byte_in[2:0]};
               pending_in = 2'd3;
               fail       = req_end_of_string;
            end
            default: begin
               fail = 1'b1;
            end
         endcase
      end else if (req_byte_in[7:6] != 2'b10) begin
         fail = 1'b1;
      end else begin
         accum_in   = {accum_ff[u8u16_pkg::ACCUM_WIDTH-7:0],
                       req_byte_in[5:0] & u8u16_pkg::CONT_MASK};
         pending_in = pending_ff - 2'd1;
         if (pending_in == 2'd0) begin
            cp       = accum_in;
            accum_in = '0;
            emit_cp  = 1'b1;
         end else begin
            fail = req_end_of_string;
         end
      end

      // A completed code point may still be a surrogate or out of range.
      bad_cp = (cp >= u8u16_pkg::SURR_LOW && cp <= u8u16_pkg::SURR_HIGH) ||
               (cp > u8u16_pkg::CP_MAX);
      if (emit_cp && bad_cp) begin
         fail = 1'b1;
      end
      if (fail) begin
         pending_in = 2'd0;
         accum_in   = '0;
      end
   end

   assign supp = cp - u8u16_pkg::SUPP_BASE;

   always_comb begin
      push_entry = '0;
      push       = accept && (fail || emit_cp);
      if (fail) begin
         push_entry.is_error = 1'b1;
      end else if (cp > u8u16_pkg::BMP_MAX) begin
         push_entry.is_pair     = 1'b1;
         push_entry.unit_first  = {u8u16_pkg::HIGH_SURR_TOP, supp[19:10]};
         push_entry.unit_second = {u8u16_pkg::LOW_SURR_TOP, supp[9:0]};
      end else begin
         push_entry.unit_first = cp[u8u16_pkg::UNIT_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 2'd0;
         accum_ff   <= '0;
      end else if (accept) begin
         pending_ff <= pending_in;
         accum_ff   <= accum_in;
      end
   end

endmodule

// ===== src/u8u16_queue.sv =====
module u8u16_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  u8u16_pkg::entry_type push_entry,
   input  logic                 pop,
   output u8u16_pkg::entry_type head_entry,
   output u8u16_pkg::queue_status_type q_status
);

   localparam int unsigned PTR_WIDTH   = $clog2(DEPTH);
   localparam int unsigned COUNT_WIDTH = $clog2(DEPTH + 1);
   localparam logic [PTR_WIDTH-1:0]   LAST_SLOT = PTR_WIDTH'(DEPTH - 1);
   localparam logic [COUNT_WIDTH-1:0] FULL_COUNT = COUNT_WIDTH'(DEPTH);

   u8u16_pkg::entry_type          slots_ff [DEPTH];
   logic [PTR_WIDTH-1:0]          wr_ptr_ff, rd_ptr_ff;
   logic [COUNT_WIDTH-1:0]        count_ff;

   assign head_entry     = slots_ff[rd_ptr_ff];
   assign q_status.full  = (count_ff == FULL_COUNT);
   assign q_status.empty = (count_ff == '0);

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + PTR_WIDTH'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + PTR_WIDTH'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + COUNT_WIDTH'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - COUNT_WIDTH'(1);
         end
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset) push |-> !q_status.full)
      else $error("queue written while full");
   assert property (@(posedge clock) disable iff (reset) pop |-> !q_status.empty)
      else $error("queue read while empty");
   assert property (@(posedge clock) disable iff (reset) count_ff <= FULL_COUNT)
      else $error("queue count beyond its depth");
`endif

endmodule

// ===== src/u8u16_back.sv =====
module u8u16_back (
   input  logic                 clock,
   input  logic                 reset,
   input  u8u16_pkg::entry_type head_entry,
   input  u8u16_pkg::queue_status_type q_status,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [15:0]          rsp_code_unit,
   output logic                 rsp_error,
   output logic                 rsp_last
);

   logic        valid_ff;
   logic [15:0] unit_ff;
   logic        error_ff;
   logic        last_ff;
   logic        second_ff;
   logic [15:0] second_unit_ff;
   logic        out_free;

   assign out_free = !valid_ff || !rsp_stall;
   assign pop      = out_free && !second_ff && !q_status.empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else if (out_free) begin
         if (second_ff) begin
            valid_ff  <= 1'b1;
            second_ff <= 1'b0;
            unit_ff   <= second_unit_ff;
            error_ff  <= 1'b0;
            last_ff   <= 1'b1;
         end else if (!q_status.empty) begin
            valid_ff       <= 1'b1;
            second_ff      <= head_entry.is_pair;
            second_unit_ff <= head_entry.unit_second;
            unit_ff        <= head_entry.unit_first;
            error_ff       <= head_entry.is_error;
            last_ff        <= !head_entry.is_pair;
         end else begin
            valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_code_unit = unit_ff;
   assign rsp_error     = error_ff;
   assign rsp_last      = last_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset) second_ff |-> valid_ff)
      else $error("low surrogate pending without a high surrogate shown");
   assert property (@(posedge clock) disable iff (reset)
                    (valid_ff && error_ff) |-> (last_ff && unit_ff == 16'd0 && !second_ff))
      else $error("error result is not a lone zero unit");
   assert property (@(posedge clock) disable iff (reset) (valid_ff && !last_ff) |-> second_ff)
      else $error("result without last flag and no low surrogate to follow");
`endif

endmodule

// ===== src/utf8_to_utf16_decoder.sv =====
// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_stall   req_byte_in[7:0], req_end_of_string
// rsp_      out        rsp_valid/rsp_stall   rsp_code_unit[15:0], rsp_error, rsp_last
//
// One byte is taken per cycle while the queue has room. A result is written
// into the queue and then into the back's output register before it is shown
// on rsp_. A code point above the basic plane gives two results, the high and
// then the low surrogate, with no result from the queue between them.
// Reset is synchronous and active high; it empties the queue and the decoder.
// req_stall is raised only when the QUEUE_DEPTH-entry queue is full.
module utf8_to_utf16_decoder #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_byte_in,
   input  logic        req_end_of_string,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_code_unit,
   output logic        rsp_error,
   output logic        rsp_last
);

   // The front decodes each accepted byte combinationally, tracking the open
   // sequence in registers, and turns every completed code point or every
   // malformation into one queue entry. The queue decouples it from the
   // back, which expands entries into one or two code unit transfers.
   // QUEUE_DEPTH must be at least two.

   u8u16_pkg::entry_type        push_entry;
   u8u16_pkg::entry_type        head_entry;
   u8u16_pkg::queue_status_type q_status;
   logic                        push;
   logic                        pop;

   u8u16_front front_u (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_byte_in       (req_byte_in),
      .req_end_of_string (req_end_of_string),
      .q_status          (q_status),
      .push              (push),
      .push_entry        (push_entry)
   );

   u8u16_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) queue_u (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .q_status   (q_status)
   );

   // The back holds the result in a register. While a shown transfer waits it
   // takes nothing from the queue, and the front keeps filling the queue
   // meanwhile.
   u8u16_back back_u (
      .clock         (clock),
      .reset         (reset),
      .head_entry    (head_entry),
      .q_status      (q_status),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_code_unit (rsp_code_unit),
      .rsp_error     (rsp_error),
      .rsp_last      (rsp_last)
   );

endmodule
